### hdl/clt_pkg.sv
`default_nettype none

package clt_pkg;

  // Widths of the stream fields and of the token counter.
  localparam int COUNT_BITS = 16;
  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 2;
  localparam int TOTAL_W    = 16;
  localparam int MAX_RES    = 3;
  localparam int NUM_W      = 2;
  localparam int RES_BITS   = KIND_W + CHAR_W + TOTAL_W;
  localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int OUT_PAD    = OUT_DATA_W - RES_BITS;

  // Characters that steer the lexer.
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_LINE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // Lexer mode, one-hot.
  typedef enum logic [6:0] {
    MODE_PLAIN    = 7'b0000001,
    MODE_PLAIN_BS = 7'b0000010,
    MODE_DQ       = 7'b0000100,
    MODE_DQ_BS    = 7'b0001000,
    MODE_SQ       = 7'b0010000,
    MODE_SQ_BS    = 7'b0100000,
    MODE_SKIP     = 7'b1000000
  } mode_e;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    kind_e               kind;
    logic [CHAR_W-1:0]   ch;
    logic [TOTAL_W-1:0]  total;
  } result_t;

  // All results caused by one byte, slot 0 first.
  typedef struct packed {
    logic [NUM_W-1:0]          num;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

  // Saturating increment of the token counter.
  function automatic count_t sat_inc(input count_t c);
    count_t r;
    r = c;
    if (c != {COUNT_BITS{1'b1}}) begin
      r = c + count_t'(1);
    end
    return r;
  endfunction

  // Token total as reported, clipped to the field width.
  function automatic logic [TOTAL_W-1:0] total_of(input count_t c);
    logic [COUNT_BITS+TOTAL_W-1:0] wide;
    logic [TOTAL_W-1:0]            r;
    wide = {{TOTAL_W{1'b0}}, c};
    r    = wide[TOTAL_W-1:0];
    if (wide > {{COUNT_BITS{1'b0}}, {TOTAL_W{1'b1}}}) begin
      r = {TOTAL_W{1'b1}};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

### hdl/clt_lexer.sv
`default_nettype none

module clt_lexer
  import clt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [CHAR_W-1:0] char_i,
  output      bundle_t           bundle_o
);

  mode_e  mode_q, mode_d;
  logic   open_q, open_d;
  count_t count_q, count_d;

  // Line state; it only moves when a byte is stepped through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      open_q  <= 1'b0;
      count_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      open_q  <= open_d;
      count_q <= count_d;
    end
  end

  result_t r_char, r_end, r_err, r_none;
  count_t  cnt_closed;

  assign r_char     = '{kind: KIND_CHAR, ch: char_i, total: '0};
  assign r_end      = '{kind: KIND_END, ch: '0, total: '0};
  assign r_err      = '{kind: KIND_ERR, ch: '0, total: '0};
  assign r_none     = '{kind: KIND_CHAR, ch: '0, total: '0};
  assign cnt_closed = open_q ? sat_inc(count_q) : count_q;

  // Next line state and the results of this byte.
  always_comb begin
    result_t r_line;
    r_line   = '{kind: KIND_LINE, ch: '0, total: total_of(cnt_closed)};
    mode_d   = mode_q;
    open_d   = open_q;
    count_d  = count_q;
    bundle_o.num = '0;
    bundle_o.res = {MAX_RES{r_none}};

    case (mode_q)
      MODE_PLAIN: begin
        if (char_i == CH_NUL) begin
          if (open_q) begin
            bundle_o.res[0] = r_end;
            bundle_o.res[1] = r_line;
            bundle_o.num    = NUM_W'(2);
          end else begin
            bundle_o.res[0] = r_line;
            bundle_o.num    = NUM_W'(1);
          end
          mode_d  = MODE_PLAIN;
          open_d  = 1'b0;
          count_d = '0;
        end else if (is_space(char_i)) begin
          if (open_q) begin
            bundle_o.res[0] = r_end;
            bundle_o.num    = NUM_W'(1);
          end
          open_d  = 1'b0;
          count_d = cnt_closed;
        end else if ((char_i == CH_LPAREN) || (char_i == CH_RPAREN) ||
                     (char_i == CH_EQUAL)) begin
          // The character forms a token of its own.
          if (open_q) begin
            bundle_o.res[0] = r_end;
            bundle_o.res[1] = r_char;
            bundle_o.res[2] = r_end;
            bundle_o.num    = NUM_W'(3);
          end else begin
            bundle_o.res[0] = r_char;
            bundle_o.res[1] = r_end;
            bundle_o.num    = NUM_W'(2);
          end
          open_d  = 1'b0;
          count_d = sat_inc(cnt_closed);
        end else if (char_i == CH_DQUOTE) begin
          mode_d = MODE_DQ;
        end else if (char_i == CH_SQUOTE) begin
          mode_d = MODE_SQ;
        end else if (char_i == CH_HASH) begin
          if (open_q) begin
            bundle_o.res[0] = r_end;
            bundle_o.num    = NUM_W'(1);
          end
          open_d  = 1'b0;
          count_d = cnt_closed;
          mode_d  = MODE_SKIP;
        end else if (char_i == CH_BSLASH) begin
          mode_d = MODE_PLAIN_BS;
        end else begin
          bundle_o.res[0] = r_char;
          bundle_o.num    = NUM_W'(1);
          open_d          = 1'b1;
        end
      end
      MODE_PLAIN_BS, MODE_DQ_BS, MODE_SQ_BS: begin
        if (char_i == CH_NUL) begin
          bundle_o.res[0] = r_err;
          bundle_o.num    = NUM_W'(1);
          mode_d  = MODE_PLAIN;
          open_d  = 1'b0;
          count_d = '0;
        end else begin
          bundle_o.res[0] = r_char;
          bundle_o.num    = NUM_W'(1);
          open_d          = 1'b1;
          if (mode_q == MODE_DQ_BS) begin
            mode_d = MODE_DQ;
          end else if (mode_q == MODE_SQ_BS) begin
            mode_d = MODE_SQ;
          end else begin
            mode_d = MODE_PLAIN;
          end
        end
      end
      MODE_DQ, MODE_SQ: begin
        if (char_i == CH_NUL) begin
          bundle_o.res[0] = r_err;
          bundle_o.num    = NUM_W'(1);
          mode_d  = MODE_PLAIN;
          open_d  = 1'b0;
          count_d = '0;
        end else if (((mode_q == MODE_DQ) && (char_i == CH_DQUOTE)) ||
                     ((mode_q == MODE_SQ) && (char_i == CH_SQUOTE))) begin
          mode_d = MODE_PLAIN;
        end else if (char_i == CH_BSLASH) begin
          mode_d = (mode_q == MODE_DQ) ? MODE_DQ_BS : MODE_SQ_BS;
        end else begin
          bundle_o.res[0] = r_char;
          bundle_o.num    = NUM_W'(1);
          open_d          = 1'b1;
        end
      end
      default: begin
        // Skip mode: swallow bytes until the end of the line.
        if (char_i == CH_NUL) begin
          if (open_q) begin
            bundle_o.res[0] = r_end;
            bundle_o.res[1] = r_line;
            bundle_o.num    = NUM_W'(2);
          end else begin
            bundle_o.res[0] = r_line;
            bundle_o.num    = NUM_W'(1);
          end
          mode_d  = MODE_PLAIN;
          open_d  = 1'b0;
          count_d = '0;
        end else begin
          mode_d = MODE_SKIP;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/clt_result_queue.sv
`default_nettype none

module clt_result_queue
  import clt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire bundle_t               bundle_i,
  output      logic                  free_o,
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output      logic                  m_axis_tlast_o
);

  logic [NUM_W-1:0]      rem_q, rem_d;
  result_t [MAX_RES-1:0] res_q, res_d;
  logic                  pop;

  assign pop    = (rem_q != '0) && m_axis_tready_i;
  // Free when empty, or when the last pending result leaves this cycle.
  assign free_o = (rem_q == '0) || ((rem_q == NUM_W'(1)) && m_axis_tready_i);

  // Load a new bundle, or shift the pending results down by one.
  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    if (load_i) begin
      rem_d = bundle_i.num;
      res_d = bundle_i.res;
    end else if (pop) begin
      rem_d    = rem_q - NUM_W'(1);
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tlast_o  = (rem_q == NUM_W'(1));
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, res_q[0].total, res_q[0].ch, res_q[0].kind};

endmodule

`default_nettype wire

### hdl/command_line_tokenizer_unit.sv
// Shell-style command line lexer, one byte per transfer.
// Slave channel: s_axis_tdata_i carries one byte of the line; a zero byte ends
// the line. Master channel: one result per transfer with kind (token
// character, token end, line done, error), the character, the token total
// of the line (meaningful on line done) and tlast on the final result that a
// byte causes. A byte may cause zero to three results.
// An accepted byte sits in the input register and is lexed into the result
// register once the result queue is free; its results are offered from there.
// Throughput: one byte per cycle as long as each byte yields at most one
// result and the receiver does not stall; a byte with more results holds the
// next one in the input register, set by the single result queue that drains
// one entry per cycle while the receiver is ready.
// Reset puts the lexer in plain mode with no open token and a zero count,
// and empties both registers. When the receiver stalls, the pending results
// hold, one more byte waits in the input register, and tready then drops.
`default_nettype none

module command_line_tokenizer_unit
  import clt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  input  wire logic [CHAR_W-1:0]     s_axis_tdata_i,  // [7:0] char_in
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [1:0] kind, [9:2] char_out, [25:10] token_total, [31:26] zero
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output      logic                  m_axis_tlast_o   // last_of_run
);

  logic              byte_vld_q;
  logic [CHAR_W-1:0] byte_q;
  logic              queue_free;
  logic              advance;
  bundle_t           bundle;

  assign advance         = byte_vld_q && queue_free;
  assign s_axis_tready_o = !byte_vld_q || queue_free;

  // Input register: holds one byte while the result side is busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      byte_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  clt_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .char_i   (byte_q),
    .bundle_o (bundle)
  );

  clt_result_queue u_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .bundle_i        (bundle),
    .free_o          (queue_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Line done and error always end the results of their byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tdata_o[1:0] == KIND_LINE) ||
                        (m_axis_tdata_o[1:0] == KIND_ERR)) |-> m_axis_tlast_o)
    else $error("line done or error result not marked last");

  // Only token characters carry a character, only line done a total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != KIND_CHAR) |->
      (m_axis_tdata_o[9:2] == '0))
    else $error("non-character result carries a character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != KIND_LINE) |->
      (m_axis_tdata_o[25:10] == '0))
    else $error("total reported outside line done");

  // Back pressure on the input only when a byte is already held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> byte_vld_q && m_axis_tvalid_o)
    else $error("input stalled without a held byte");

endmodule

`default_nettype wire
